[design/sifp_pkg.sv]
// Package for the system instruction field parser.
// Holds field tags, status codes, the per-kind layout and account tables,
// and the record passed from the front end to the back end.
package sifp_pkg;

    localparam int NUM_KINDS  = 13;
    localparam int LAYOUT_LEN = 7;
    localparam int STEP_W     = 3;
    localparam int OFF_W      = 11;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;

    localparam logic [3:0] KIND_NONE = 4'd13;

    typedef enum logic [3:0] {
        TAG_KIND    = 4'd0,
        TAG_AMOUNT  = 4'd1,
        TAG_SPACE   = 4'd2,
        TAG_OWNER   = 4'd3,
        TAG_BASE    = 4'd4,
        TAG_SEEDLEN = 4'd5,
        TAG_SEED    = 4'd6,
        TAG_NEWAUTH = 4'd7,
        TAG_IGNORED = 4'd8
    } t_tag;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_UNKNOWN  = 3'd2,
        ST_MISSING  = 3'd3,
        ST_SEEDLONG = 3'd4
    } t_status;

    typedef struct packed {
        logic             kind_ok;
        logic [3:0]       kind;
        t_tag             tag;
        logic [OFF_W-1:0] off;
        logic [7:0]       data;
        logic             last;
        t_status          status;
    } t_rec;

    localparam logic [3:0] LAYOUT_TAB [NUM_KINDS][LAYOUT_LEN] = '{
        '{4'd1, 4'd2, 4'd3, 4'd8, 4'd8, 4'd8, 4'd8},
        '{4'd3, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8},
        '{4'd1, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8},
        '{4'd4, 4'd5, 4'd6, 4'd1, 4'd2, 4'd3, 4'd8},
        '{4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8},
        '{4'd1, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8},
        '{4'd7, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8},
        '{4'd7, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8},
        '{4'd2, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8},
        '{4'd4, 4'd5, 4'd6, 4'd2, 4'd3, 4'd8, 4'd8},
        '{4'd4, 4'd5, 4'd6, 4'd3, 4'd8, 4'd8, 4'd8},
        '{4'd1, 4'd5, 4'd6, 4'd3, 4'd8, 4'd8, 4'd8},
        '{4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8}
    };

    function automatic t_tag layout_tag(input logic [3:0] kind, input logic [2:0] idx);
        t_tag res;
        if (kind >= 4'(NUM_KINDS) || idx >= 3'(LAYOUT_LEN)) begin
            res = TAG_IGNORED;
        end else begin
            res = t_tag'(LAYOUT_TAB[kind][idx]);
        end
        return res;
    endfunction

    function automatic logic [2:0] need_accounts(input logic [3:0] kind);
        logic [2:0] res;
        unique case (kind)
            4'd0:    res = 3'd2;
            4'd1:    res = 3'd1;
            4'd2:    res = 3'd2;
            4'd3:    res = 3'd2;
            4'd4:    res = 3'd3;
            4'd5:    res = 3'd5;
            4'd6:    res = 3'd1;
            4'd7:    res = 3'd2;
            4'd8:    res = 3'd1;
            4'd9:    res = 3'd2;
            4'd10:   res = 3'd2;
            4'd11:   res = 3'd3;
            4'd12:   res = 3'd1;
            default: res = 3'd0;
        endcase
        return res;
    endfunction

    function automatic logic [4:0] field_last(input t_tag tag);
        logic [4:0] res;
        if (tag == TAG_AMOUNT || tag == TAG_SPACE || tag == TAG_SEEDLEN) begin
            res = 5'd7;
        end else begin
            res = 5'd31;
        end
        return res;
    endfunction

endpackage

[design/sifp_in_if.sv]
// Input channel of the field parser: one data byte per transaction.
// Depends on sifp_pkg.
interface sifp_in_if
    import sifp_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [7:0] num_accounts;
    logic       last_byte;

    modport source (output valid, output data_byte, output num_accounts,
                    output last_byte, input ready);
    modport sink   (input valid, input data_byte, input num_accounts,
                    input last_byte, output ready);
endinterface

[design/sifp_out_if.sv]
// Output channel of the field parser: one tagged byte per transaction.
// Depends on sifp_pkg.
interface sifp_out_if
    import sifp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [3:0]       kind_code;
    logic [3:0]       field_tag;
    logic [OFF_W-1:0] field_offset;
    logic [7:0]       byte_out;
    logic             done_res;
    logic [2:0]       status;
    logic [2:0]       accounts_needed;

    modport source (output valid, output kind_code, output field_tag,
                    output field_offset, output byte_out, output done_res,
                    output status, output accounts_needed, input ready);
    modport sink   (input valid, input kind_code, input field_tag,
                    input field_offset, input byte_out, input done_res,
                    input status, input accounts_needed, output ready);
endinterface

[design/sifp_front.sv]
// Front end of the field parser: accepts bytes, walks the per-kind layout
// and emits one classified record per byte into the queue.
// Depends on sifp_pkg and sifp_in_if.
module sifp_front
    import sifp_pkg::*;
#(
    parameter int MAX_DATA_BYTES = 2048
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sifp_in_if.sink      i_in,
    input  logic         i_full,
    output logic         o_push,
    output t_rec         o_rec
);

    localparam int SEED_W = $clog2(MAX_DATA_BYTES + 1);
    localparam logic [SEED_W-1:0] SEED_MAX = SEED_W'(MAX_DATA_BYTES);

    logic [STEP_W-1:0] r_step,    n_step;
    logic [OFF_W-1:0]  r_bif,     n_bif;
    logic [3:0]        r_klo,     n_klo;
    logic              r_khi,     n_khi;
    logic [SEED_W-1:0] r_seed,    n_seed;
    logic              r_seed_hi, n_seed_hi;
    t_status           r_err,     n_err;

    logic              w_take;
    logic              w_kvalid_cur;
    logic              w_kvalid_nxt;
    t_tag              w_tag;
    t_tag              w_end_tag;
    logic [63:0]       w_sh;
    logic              w_adv;
    logic [STEP_W-1:0] w_step1;
    t_status           w_status;

    assign i_in.ready = !i_full;
    assign w_take     = i_in.valid && i_in.ready;
    assign o_push     = w_take;

    always_comb begin
        w_kvalid_cur = (r_step != '0) && !r_khi && (r_klo < 4'(NUM_KINDS));
        if (r_step == '0) begin
            w_tag = TAG_KIND;
        end else if (!w_kvalid_cur || r_err != ST_OK) begin
            w_tag = TAG_IGNORED;
        end else begin
            w_tag = layout_tag(r_klo, r_step - 3'd1);
        end
        w_sh = 64'(i_in.data_byte) << {r_bif[2:0], 3'b000};

        n_step    = r_step;
        n_bif     = r_bif;
        n_klo     = r_klo;
        n_khi     = r_khi;
        n_seed    = r_seed;
        n_seed_hi = r_seed_hi;
        n_err     = r_err;
        w_adv     = 1'b0;

        priority if (r_err != ST_OK) begin
            n_bif = r_bif + 11'd1;
        end else if (r_step == '0) begin
            if (r_bif[1:0] == 2'd0) begin
                n_klo = r_klo | i_in.data_byte[3:0];
                n_khi = r_khi | (|i_in.data_byte[7:4]);
            end else begin
                n_khi = r_khi | (|i_in.data_byte);
            end
            n_bif = r_bif + 11'd1;
            if (r_bif[1:0] == 2'd3) begin
                n_step = 3'd1;
                n_bif  = '0;
                if (n_khi || n_klo >= 4'(NUM_KINDS)) begin
                    n_err = ST_UNKNOWN;
                end else if (i_in.num_accounts < 8'(need_accounts(n_klo))) begin
                    n_err = ST_MISSING;
                end
            end
        end else if (w_tag == TAG_IGNORED) begin
            n_bif = r_bif + 11'd1;
        end else if (w_tag == TAG_SEED) begin
            n_seed = r_seed - SEED_W'(1);
            n_bif  = r_bif + 11'd1;
            w_adv  = (n_seed == '0) && !n_seed_hi;
        end else begin
            if (w_tag == TAG_SEEDLEN) begin
                n_seed    = r_seed | w_sh[SEED_W-1:0];
                n_seed_hi = r_seed_hi | (|w_sh[63:SEED_W]);
            end
            n_bif = r_bif + 11'd1;
            if (r_bif[4:0] == field_last(w_tag)) begin
                if (w_tag == TAG_SEEDLEN && (n_seed_hi || n_seed > SEED_MAX)) begin
                    n_err = ST_SEEDLONG;
                end
                w_adv = 1'b1;
            end
        end

        w_step1 = (r_step < 3'(LAYOUT_LEN)) ? r_step + 3'd1 : r_step;
        if (w_adv) begin
            n_bif = '0;
            if (layout_tag(r_klo, w_step1 - 3'd1) == TAG_SEED && n_seed == '0
                && !n_seed_hi && w_step1 < 3'(LAYOUT_LEN)) begin
                n_step = w_step1 + 3'd1;
            end else begin
                n_step = w_step1;
            end
        end

        w_kvalid_nxt = (n_step != '0) && !n_khi && (n_klo < 4'(NUM_KINDS));
        w_end_tag    = layout_tag(n_klo, n_step - 3'd1);
        if (!i_in.last_byte) begin
            w_status = ST_OK;
        end else if (n_err != ST_OK) begin
            w_status = n_err;
        end else if (n_step == '0) begin
            w_status = ST_SHORT;
        end else if (w_end_tag == TAG_IGNORED) begin
            w_status = ST_OK;
        end else if (w_end_tag == TAG_SEED) begin
            w_status = ST_SEEDLONG;
        end else begin
            w_status = ST_SHORT;
        end

        o_rec.kind_ok = w_kvalid_nxt;
        o_rec.kind    = n_klo;
        o_rec.tag     = w_tag;
        o_rec.off     = r_bif;
        o_rec.data    = i_in.data_byte;
        o_rec.last    = i_in.last_byte;
        o_rec.status  = w_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_take && i_in.last_byte)) begin
            r_step    <= '0;
            r_bif     <= '0;
            r_klo     <= '0;
            r_khi     <= 1'b0;
            r_seed    <= '0;
            r_seed_hi <= 1'b0;
            r_err     <= ST_OK;
        end else if (w_take) begin
            r_step    <= n_step;
            r_bif     <= n_bif;
            r_klo     <= n_klo;
            r_khi     <= n_khi;
            r_seed    <= n_seed;
            r_seed_hi <= n_seed_hi;
            r_err     <= n_err;
        end
    end

endmodule

[design/sifp_fifo.sv]
// Short record queue between the parser front end and the output stage.
// Depends on sifp_pkg.
module sifp_fifo
    import sifp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_rec o_rec
);

    t_rec              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W + 1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[design/sifp_back.sv]
// Output stage of the field parser: maps queued records to the kind code
// and account need, and holds them in the output register.
// Depends on sifp_pkg and sifp_out_if.
module sifp_back
    import sifp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_rec       i_rec,
    output logic       o_pop,
    sifp_out_if.source o_out
);

    logic             r_valid;
    logic [3:0]       r_kind;
    logic [3:0]       r_tag;
    logic [OFF_W-1:0] r_off;
    logic [7:0]       r_data;
    logic             r_last;
    logic [2:0]       r_status;
    logic [2:0]       r_need;

    assign o_pop = i_valid && (!r_valid || o_out.ready);

    assign o_out.valid           = r_valid;
    assign o_out.kind_code       = r_kind;
    assign o_out.field_tag       = r_tag;
    assign o_out.field_offset    = r_off;
    assign o_out.byte_out        = r_data;
    assign o_out.done_res        = r_last;
    assign o_out.status          = r_status;
    assign o_out.accounts_needed = r_need;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind   <= i_rec.kind_ok ? i_rec.kind : KIND_NONE;
            r_need   <= i_rec.kind_ok ? need_accounts(i_rec.kind) : 3'd0;
            r_tag    <= i_rec.tag;
            r_off    <= i_rec.off;
            r_data   <= i_rec.data;
            r_last   <= i_rec.last;
            r_status <= i_rec.status;
        end
    end

endmodule

[design/system_instruction_field_parser.sv]
// System instruction field parser, top level.
// Input channel i_in carries one instruction data byte per transaction, with
// the instruction's account count and a last-byte flag. Output channel o_out
// carries one result per input byte: the byte, its field tag and offset, the
// decoded kind and accounts needed, and on the last byte a status.
// The first four bytes form the little-endian kind; a kind past 12 or an
// account count below the kind's need latches an error and later bytes are
// tagged ignored. A seed length above MAX_DATA_BYTES latches seed too long.
// Throughput: one byte per cycle while the queue is not full, with no gaps
// between instructions. The front end updates the layout walker in the
// cycle of acceptance; the record is written into the queue and from there
// into the output register, which holds the result shown on o_out.
// A four-entry queue sits between the walker and the output register; when
// o_out stalls the queue fills and i_in.ready drops once it is full, and no
// result is lost. Synchronous active-low reset empties the queue, clears the
// output valid and returns the walker to the kind field; the same return
// happens after every last byte.
// Depends on sifp_pkg, sifp_in_if, sifp_out_if, sifp_front, sifp_fifo,
// sifp_back.
module system_instruction_field_parser
    import sifp_pkg::*;
#(
    parameter int MAX_DATA_BYTES = 2048
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sifp_in_if.sink    i_in,
    sifp_out_if.source o_out
);

    logic w_push;
    logic w_full;
    logic w_qvalid;
    logic w_pop;
    t_rec w_front_rec;
    t_rec w_queue_rec;

    sifp_front #(
        .MAX_DATA_BYTES(MAX_DATA_BYTES)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push),
        .o_rec  (w_front_rec)
    );

    sifp_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_rec  (w_front_rec),
        .i_pop  (w_pop),
        .o_full (w_full),
        .o_valid(w_qvalid),
        .o_rec  (w_queue_rec)
    );

    sifp_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_qvalid),
        .i_rec  (w_queue_rec),
        .o_pop  (w_pop),
        .o_out  (o_out)
    );

endmodule

[design/sifp_checker.sv]
// Port-level checks for the system instruction field parser, with the bind
// that attaches them to the top level. Depends on sifp_pkg.
module sifp_checker
    import sifp_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [3:0]       i_kind_code,
    input logic [3:0]       i_field_tag,
    input logic [OFF_W-1:0] i_field_offset,
    input logic [7:0]       i_byte_out,
    input logic             i_done_res,
    input logic [2:0]       i_status,
    input logic [2:0]       i_accounts_needed
);

    a_status_only_when_done: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_done_res) |-> (i_status == ST_OK)
    ) else $error("status set on a byte that is not last");

    a_no_kind_no_need: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_kind_code == KIND_NONE) |-> (i_accounts_needed == 3'd0)
    ) else $error("accounts needed reported without a valid kind");

    a_kind_pending: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_field_tag == TAG_KIND && i_field_offset != 11'd3)
            |-> (i_kind_code == KIND_NONE)
    ) else $error("kind reported before its fourth byte");

    a_hold_on_stall: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid
            && $stable({i_kind_code, i_field_tag, i_field_offset, i_byte_out,
                        i_done_res, i_status, i_accounts_needed}))
    ) else $error("output transaction changed while stalled");

endmodule

bind system_instruction_field_parser sifp_checker u_sifp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_kind_code      (o_out.kind_code),
    .i_field_tag      (o_out.field_tag),
    .i_field_offset   (o_out.field_offset),
    .i_byte_out       (o_out.byte_out),
    .i_done_res       (o_out.done_res),
    .i_status         (o_out.status),
    .i_accounts_needed(o_out.accounts_needed)
);

[tb/sv/tb_top.sv]
// Testbench for system_instruction_field_parser: directed and random instructions
// go through the byte channel, and each tagged byte is checked against a local walker.
// Depends on sifp_pkg, sifp_in_if, sifp_out_if and the parser RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sifp_pkg::*;

    localparam int SEED_CAP    = 2048;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int SEED_KINDS [4] = '{3, 9, 10, 11};

    localparam logic [2:0] ACCT_NEED [NUM_KINDS] = '{
        3'd2, 3'd1, 3'd2, 3'd2, 3'd3, 3'd5, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3, 3'd1
    };

    localparam t_tag FIELD_MAP [NUM_KINDS][LAYOUT_LEN] = '{
        '{TAG_AMOUNT, TAG_SPACE, TAG_OWNER, TAG_IGNORED, TAG_IGNORED, TAG_IGNORED,
          TAG_IGNORED},
        '{TAG_OWNER, TAG_IGNORED, TAG_IGNORED, TAG_IGNORED, TAG_IGNORED, TAG_IGNORED,
          TAG_IGNORED},
        '{TAG_AMOUNT, TAG_IGNORED, TAG_IGNORED, TAG_IGNORED, TAG_IGNORED, TAG_IGNORED,
          TAG_IGNORED},
        '{TAG_BASE, TAG_SEEDLEN, TAG_SEED, TAG_AMOUNT, TAG_SPACE, TAG_OWNER, TAG_IGNORED},
        '{TAG_IGNORED, TAG_IGNORED, TAG_IGNORED, TAG_IGNORED, TAG_IGNORED, TAG_IGNORED,
          TAG_IGNORED},
        '{TAG_AMOUNT, TAG_IGNORED, TAG_IGNORED, TAG_IGNORED, TAG_IGNORED, TAG_IGNORED,
          TAG_IGNORED},
        '{TAG_NEWAUTH, TAG_IGNORED, TAG_IGNORED, TAG_IGNORED, TAG_IGNORED, TAG_IGNORED,
          TAG_IGNORED},
        '{TAG_NEWAUTH, TAG_IGNORED, TAG_IGNORED, TAG_IGNORED, TAG_IGNORED, TAG_IGNORED,
          TAG_IGNORED},
        '{TAG_SPACE, TAG_IGNORED, TAG_IGNORED, TAG_IGNORED, TAG_IGNORED, TAG_IGNORED,
          TAG_IGNORED},
        '{TAG_BASE, TAG_SEEDLEN, TAG_SEED, TAG_SPACE, TAG_OWNER, TAG_IGNORED, TAG_IGNORED},
        '{TAG_BASE, TAG_SEEDLEN, TAG_SEED, TAG_OWNER, TAG_IGNORED, TAG_IGNORED,
          TAG_IGNORED},
        '{TAG_AMOUNT, TAG_SEEDLEN, TAG_SEED, TAG_OWNER, TAG_IGNORED, TAG_IGNORED,
          TAG_IGNORED},
        '{TAG_IGNORED, TAG_IGNORED, TAG_IGNORED, TAG_IGNORED, TAG_IGNORED, TAG_IGNORED,
          TAG_IGNORED}
    };

    typedef struct packed {
        logic [3:0]       kind;
        t_tag             tag;
        logic [OFF_W-1:0] off;
        logic [7:0]       data;
        logic             done;
        t_status          status;
        logic [2:0]       need;
    } t_tagged_byte;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sifp_in_if  in_if ();
    sifp_out_if out_if ();

    system_instruction_field_parser #(
        .MAX_DATA_BYTES(SEED_CAP)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // layout walker state
    int unsigned walk_step;
    int unsigned walk_off;
    logic [31:0] walk_kind;
    logic [63:0] walk_seed;
    t_status     walk_err;

    t_tagged_byte expected_bytes [$];
    logic [7:0]   instr_bytes [$];

    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    int unsigned bytes_sent;
    int unsigned instr_count;
    int unsigned results_checked;
    int unsigned mismatches;
    int unsigned cycle_count;
    int unsigned status_seen [5];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     expected_bytes.size());
            $display("FAILURE");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic int unsigned field_size(input t_tag f);
        return (f == TAG_AMOUNT || f == TAG_SPACE || f == TAG_SEEDLEN) ? 8 : 32;
    endfunction

    function automatic logic walk_kind_ok();
        return walk_step > 0 && walk_kind < NUM_KINDS;
    endfunction

    function automatic t_tag walk_tag();
        int unsigned idx;
        if (walk_step == 0) return TAG_KIND;
        if (!walk_kind_ok()) return TAG_IGNORED;
        idx = walk_step - 1;
        if (idx >= LAYOUT_LEN) idx = LAYOUT_LEN - 1;
        return FIELD_MAP[walk_kind[3:0]][idx];
    endfunction

    function automatic void walk_reset();
        walk_step = 0;
        walk_off  = 0;
        walk_kind = '0;
        walk_seed = '0;
        walk_err  = ST_OK;
    endfunction

    // advance to the next layout field, skipping an empty seed
    function automatic void walk_next_field();
        if (walk_step < LAYOUT_LEN) walk_step++;
        walk_off = 0;
        if (walk_tag() == TAG_SEED && walk_seed == 0 && walk_step < LAYOUT_LEN) walk_step++;
    endfunction

    function automatic t_tagged_byte tag_byte(input logic [7:0] b, input logic [7:0] acc,
                                              input logic last);
        t_tagged_byte r;
        t_tag         f;
        r.off    = walk_off[OFF_W-1:0];
        r.status = ST_OK;
        if (walk_err != ST_OK) begin
            f = TAG_IGNORED;
            walk_off = (walk_off + 1) & 32'h7FF;
        end else if (walk_step == 0) begin
            f = TAG_KIND;
            walk_kind |= 32'(b) << (8 * (walk_off % 4));
            walk_off++;
            if (walk_off >= 4) begin
                walk_step = 1;
                walk_off  = 0;
                if (walk_kind >= NUM_KINDS) begin
                    walk_err = ST_UNKNOWN;
                end else if (acc < ACCT_NEED[walk_kind[3:0]]) begin
                    walk_err = ST_MISSING;
                end
            end
        end else begin
            f = walk_tag();
            if (f == TAG_IGNORED) begin
                walk_off = (walk_off + 1) & 32'h7FF;
            end else if (f == TAG_SEED) begin
                walk_seed--;
                walk_off = (walk_off + 1) & 32'h7FF;
                if (walk_seed == 0) walk_next_field();
            end else begin
                if (f == TAG_SEEDLEN) walk_seed |= 64'(b) << (8 * (walk_off % 8));
                walk_off++;
                if (walk_off >= field_size(f)) begin
                    if (f == TAG_SEEDLEN && walk_seed > 64'(SEED_CAP)) walk_err = ST_SEEDLONG;
                    walk_next_field();
                    if (walk_err != ST_OK) walk_off = 0;
                end
            end
        end
        r.tag  = f;
        r.kind = walk_kind_ok() ? walk_kind[3:0] : KIND_NONE;
        r.need = walk_kind_ok() ? ACCT_NEED[walk_kind[3:0]] : 3'd0;
        r.data = b;
        r.done = last;
        if (last) begin
            if (walk_err != ST_OK) begin
                r.status = walk_err;
            end else if (walk_step == 0) begin
                r.status = ST_SHORT;
            end else begin
                case (walk_tag())
                    TAG_IGNORED: r.status = ST_OK;
                    TAG_SEED:    r.status = ST_SEEDLONG;
                    default:     r.status = ST_SHORT;
                endcase
            end
            walk_reset();
        end
        return r;
    endfunction

    function automatic void build_instr(input logic [31:0] kind_word,
                                        input logic [63:0] seed_len,
                                        input int unsigned seed_n,
                                        input int unsigned trailing);
        t_tag        f;
        int unsigned len;
        instr_bytes.delete();
        for (int i = 0; i < 4; i++) instr_bytes.push_back(kind_word[8*i +: 8]);
        if (kind_word < NUM_KINDS) begin
            for (int s = 0; s < LAYOUT_LEN; s++) begin
                f = FIELD_MAP[kind_word[3:0]][s];
                if (f == TAG_IGNORED) break;
                len = (f == TAG_SEED) ? seed_n : field_size(f);
                for (int i = 0; i < len; i++) begin
                    if (f == TAG_SEEDLEN) begin
                        instr_bytes.push_back(seed_len[8*i +: 8]);
                    end else begin
                        instr_bytes.push_back(8'($urandom_range(255)));
                    end
                end
            end
        end
        repeat (trailing) instr_bytes.push_back(8'($urandom_range(255)));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic [7:0] acc, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.data_byte    <= b;
        in_if.num_accounts <= acc;
        in_if.last_byte    <= last;
        do @(posedge i_clk); while (!in_if.ready);
        expected_bytes.push_back(tag_byte(b, acc, last));
        bytes_sent++;
    endtask

    // send the first keep bytes of the built instruction, all of it when keep is 0
    task automatic send_instr(input logic [7:0] acc, input int unsigned keep);
        int unsigned n;
        n = (keep == 0 || keep > instr_bytes.size()) ? instr_bytes.size() : keep;
        for (int unsigned i = 0; i < n; i++) send_byte(instr_bytes[i], acc, i == n - 1);
        instr_count++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_tagged_byte want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_bytes.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected result: byte %h tag %0d off %0d", out_if.byte_out,
                             out_if.field_tag, out_if.field_offset);
                end
                mismatches++;
            end else begin
                want = expected_bytes.pop_front();
                results_checked++;
                if (out_if.done_res === 1'b1 && out_if.status <= ST_SEEDLONG) begin
                    status_seen[out_if.status]++;
                end
                if (out_if.kind_code !== want.kind || out_if.field_tag !== want.tag ||
                    out_if.field_offset !== want.off || out_if.byte_out !== want.data ||
                    out_if.done_res !== want.done || out_if.status !== want.status ||
                    out_if.accounts_needed !== want.need) begin
                    if (mismatches < 10) begin
                        $display("mismatch at result %0d (kind tag off byte done status need)",
                                 results_checked);
                        $display("  expected %0d %0d %0d %h %0d %0d %0d", want.kind, want.tag,
                                 want.off, want.data, want.done, want.status, want.need);
                        $display("  actual   %0d %0d %0d %h %0d %0d %0d", out_if.kind_code,
                                 out_if.field_tag, out_if.field_offset, out_if.byte_out,
                                 out_if.done_res, out_if.status, out_if.accounts_needed);
                    end
                    mismatches++;
                end
            end
        end
    end

    task automatic test_kind_field();
        build_instr(32'd0, 64'd0, 0, 0);
        send_instr(8'd2, 1);
        build_instr(32'hFFFF_FFFF, 64'd0, 0, 3);
        send_instr(8'hFF, 0);
        build_instr(32'd13, 64'd0, 0, 2);
        send_instr(8'd0, 0);
        build_instr(32'h0000_0100, 64'd0, 0, 1);
        send_instr(8'hFF, 0);
        build_instr(32'd4, 64'd0, 0, 0);
        send_instr(8'd3, 0);
    endtask

    task automatic test_account_check();
        build_instr(32'd12, 64'd0, 0, 2);
        send_instr(8'd0, 0);
        build_instr(32'd5, 64'd0, 0, 0);
        send_instr(8'd4, 7);
        build_instr(32'd11, 64'd4, 4, 0);
        send_instr(8'd2, 12);
    endtask

    task automatic test_layouts();
        for (int k = 0; k < NUM_KINDS; k++) begin
            build_instr(32'(k), (k == 11) ? 64'd0 : 64'd3, (k == 11) ? 0 : 3, 1);
            send_instr((k == 0) ? 8'hFF : 8'(ACCT_NEED[k]), 0);
        end
    endtask

    task automatic test_seed_limits();
        build_instr(32'd9, 64'd5, 5, 0);
        send_instr(8'd2, 46);
        build_instr(32'd10, 64'(SEED_CAP + 1), 0, 4);
        send_instr(8'd2, 0);
        build_instr(32'd3, '1, 0, 2);
        send_instr(8'd2, 0);
        build_instr(32'd3, 64'(SEED_CAP), SEED_CAP, 1);
        send_instr(8'd2, 60);
    endtask

    task automatic test_short_data();
        build_instr(32'd0, 64'd0, 0, 0);
        send_instr(8'd2, 9);
        build_instr(32'd6, 64'd0, 0, 0);
        send_instr(8'd1, 20);
    endtask

    task automatic test_random(input int unsigned n_bytes, input int unsigned src_pct,
                               input int unsigned sink_pct);
        int unsigned start;
        int unsigned pick;
        int unsigned kind_num;
        int unsigned need;
        int unsigned seed_n;
        int unsigned keep;
        logic [7:0]  acc;
        logic [31:0] kind_word;
        logic [63:0] seed_len;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        start          = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            pick     = $urandom_range(99);
            kind_num = $urandom_range(NUM_KINDS - 1);
            need     = 32'(ACCT_NEED[kind_num]);
            acc      = ($urandom_range(3) == 0) ? 8'(need) : 8'($urandom_range(255, need));
            seed_n   = ($urandom_range(7) == 0) ? $urandom_range(200, 13) : $urandom_range(12);
            keep     = 0;
            if (pick < 60) begin
                build_instr(kind_num, 64'(seed_n), seed_n, $urandom_range(3));
            end else if (pick < 75) begin
                build_instr(kind_num, 64'(seed_n), seed_n, $urandom_range(3));
                keep = $urandom_range(instr_bytes.size(), 1);
            end else if (pick < 83) begin
                kind_word = ($urandom_range(1) == 0) ? $urandom() : $urandom_range(15, 13);
                if (kind_word < NUM_KINDS) kind_word = NUM_KINDS;
                build_instr(kind_word, 64'd0, 0, $urandom_range(6));
                acc = 8'($urandom_range(255));
            end else if (pick < 90) begin
                build_instr(kind_num, 64'(seed_n), seed_n, $urandom_range(3));
                acc = 8'($urandom_range(need - 1, 0));
            end else if (pick < 95) begin
                kind_num = SEED_KINDS[$urandom_range(3)];
                seed_len = {$urandom(), $urandom()};
                if ($urandom_range(1) == 0) seed_len = seed_len >> $urandom_range(63);
                if (seed_len <= 64'(SEED_CAP)) seed_len = 64'(SEED_CAP + 1);
                build_instr(kind_num, seed_len, 0, $urandom_range(4));
                acc = 8'($urandom_range(255, ACCT_NEED[kind_num]));
            end else begin
                instr_bytes.delete();
                repeat ($urandom_range(10, 1)) instr_bytes.push_back(8'($urandom_range(255)));
                acc = 8'($urandom_range(255));
            end
            send_instr(acc, keep);
        end
        drain();
    endtask

    initial begin
        walk_reset();
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.data_byte    = '0;
        in_if.num_accounts = '0;
        in_if.last_byte    = 1'b0;
        out_if.ready       = 1'b0;
        src_idle_pct       = 0;
        sink_stall_pct     = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_kind_field();
        test_account_check();
        test_layouts();
        test_short_data();
        test_seed_limits();
        drain();
        test_random(25, 0, 0);
        test_random(25, 83, 0);
        test_random(25, 0, 83);
        test_random(25, 16, 16);

        repeat (10) @(posedge i_clk);
        $display("checked %0d tagged bytes from %0d instructions, %0d mismatches",
                 results_checked, instr_count, mismatches);
        $display("end status: ok %0d short %0d unknown %0d missing %0d seed-long %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[files.f]
design/sifp_pkg.sv
design/sifp_in_if.sv
design/sifp_out_if.sv
design/sifp_front.sv
design/sifp_fifo.sv
design/sifp_back.sv
design/system_instruction_field_parser.sv
design/sifp_checker.sv
tb/sv/tb_top.sv
